// ----- rtl/core/twl_pkg.sv -----
`default_nettype none
package twl_pkg;

  // Layout geometry in pixels
  localparam int MAX_WINDOWS = 6;
  localparam int BAR_H       = 30;
  localparam int OUTER_GAP   = 12;
  localparam int INNER_GAP   = 12;
  localparam int SHADOW      = 4;

  localparam int AREA_LEFT   = OUTER_GAP;
  localparam int AREA_TOP    = BAR_H + OUTER_GAP;
  localparam int AREA_TRIM_X = 2 * OUTER_GAP + SHADOW;
  localparam int AREA_TRIM_Y = BAR_H + 2 * OUTER_GAP + SHADOW;

  // Start rectangle inset: shift (dx, dy) and shrink (sw, sh) per layout case
  localparam int ONE_DX  = 24;
  localparam int ONE_DY  = 16;
  localparam int ONE_SW  = 48;
  localparam int ONE_SH  = 32;
  localparam int TWO_DX  = 20;
  localparam int TWO_DY  = 12;
  localparam int TWO_SW  = 40;
  localparam int TWO_SH  = 24;
  localparam int GRID_DX = 18;
  localparam int GRID_DY = 12;
  localparam int GRID_SW = 36;
  localparam int GRID_SH = 24;

  // Smallest c with c*c >= n
  function automatic int ceil_sqrt(input int n);
    int c;
    c = 1;
    for (int i = 0; i < n; i++) begin
      if (c * c < n) c++;
    end
    return c;
  endfunction

  localparam int MAX_COLS = ceil_sqrt(MAX_WINDOWS);

  // Divide by the column count (at most MAX_COLS = 3) via reciprocal
  localparam int RECIP_SHIFT = 12;
  localparam int RECIP3      = (1 << RECIP_SHIFT) / MAX_COLS;

  typedef logic [11:0]        pix_t;
  typedef logic signed [13:0] spix_t;
  typedef logic [1:0]         grid_t;

  typedef enum logic [1:0] {
    MODE_ONE,
    MODE_TWO,
    MODE_GRID
  } mode_t;

  typedef enum logic {
    REG_SCREEN_WIDTH,
    REG_SCREEN_HEIGHT
  } reg_idx_t;

  typedef struct packed {
    grid_t col;
    grid_t row;
  } slot_t;

  // Front end to divider
  typedef struct packed {
    mode_t       mode;
    logic        right;
    grid_t       cols;
    grid_t       rows;
    grid_t       col;
    grid_t       row;
    pix_t        aw;
    pix_t        ah;
    pix_t        cw;
    pix_t        ch;
    logic [10:0] split;
  } front_t;

  // Divider to placement
  typedef struct packed {
    mode_t       mode;
    logic        right;
    grid_t       col;
    grid_t       row;
    pix_t        aw;
    pix_t        ah;
    logic [10:0] split;
    pix_t        bw;
    pix_t        bh;
    grid_t       ew;
    grid_t       eh;
  } div_t;

  function automatic grid_t grid_cols(input logic [2:0] count);
    grid_t c;
    c = 2'd1;
    for (int i = 0; i < MAX_COLS; i++) begin
      if (int'(c) * int'(c) < int'(count)) c = c + 2'd1;
    end
    return c;
  endfunction

  // Smallest r with r*cols >= count
  function automatic grid_t grid_rows(input logic [2:0] count, input grid_t cols);
    grid_t r;
    r = 2'd1;
    for (int i = 1; i < MAX_WINDOWS; i++) begin
      if (int'(r) * int'(cols) < int'(count)) r = r + 2'd1;
    end
    return r;
  endfunction

  // Row-major slot: row = pos / cols, col = pos % cols
  function automatic slot_t split_slot(input logic [2:0] pos, input grid_t cols);
    slot_t s;
    s.row = '0;
    for (int r = 1; r < MAX_WINDOWS; r++) begin
      if (int'(pos) >= r * int'(cols)) s.row = 2'(r);
    end
    s.col = 2'(int'(pos) - int'(s.row) * int'(cols));
    return s;
  endfunction

  // Total inner gap between n tiles
  function automatic pix_t gap_total(input grid_t n);
    return 12'((int'(n) - 1) * INNER_GAP);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/twl_cfg_regs.sv -----
`default_nettype none
module twl_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output twl_pkg::pix_t screen_width,
  output twl_pkg::pix_t screen_height
);
  import twl_pkg::*;

  reg_idx_t idx;
  pix_t     rd_val;

  assign idx    = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;

  // Write on the access phase of a request
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 12'd1024;
      screen_height <= 12'd768;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[11:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[11:0];
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      REG_SCREEN_WIDTH:  rd_val = screen_width;
      REG_SCREEN_HEIGHT: rd_val = screen_height;
    endcase
    prdata = {20'd0, rd_val};
  end

endmodule
`default_nettype wire

// ----- rtl/core/twl_front.sv -----
`default_nettype none
module twl_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [2:0]      open_count,
  input  logic [2:0]      slot_position,
  input  twl_pkg::pix_t   screen_width,
  input  twl_pkg::pix_t   screen_height,
  output logic            out_valid,
  output twl_pkg::front_t out_data
);
  import twl_pkg::*;

  typedef struct packed {
    mode_t mode;
    logic  right;
    grid_t cols;
    grid_t rows;
    grid_t col;
    grid_t row;
    pix_t  aw;
    pix_t  ah;
  } decode_t;

  logic [2:0]  cnt;
  logic [2:0]  pos;
  grid_t       cols;
  slot_t       slot;
  logic [12:0] aw_diff;
  logic [12:0] ah_diff;
  decode_t     dec;
  decode_t     s1;
  logic        s1_valid;
  logic [12:0] cw_diff;
  logic [12:0] ch_diff;
  logic [12:0] split_diff;
  front_t      s2_next;

  // Clamp count and rank, pick layout case, trim screen to work area
  always_comb begin
    if (open_count == 3'd0) begin
      cnt = 3'd1;
    end else if (open_count > 3'(MAX_WINDOWS)) begin
      cnt = 3'(MAX_WINDOWS);
    end else begin
      cnt = open_count;
    end
    pos     = (slot_position >= cnt) ? cnt - 3'd1 : slot_position;
    cols    = grid_cols(cnt);
    slot    = split_slot(pos, cols);
    aw_diff = {1'b0, screen_width} - 13'(AREA_TRIM_X);
    ah_diff = {1'b0, screen_height} - 13'(AREA_TRIM_Y);

    if (cnt == 3'd1) begin
      dec.mode = MODE_ONE;
    end else if (cnt == 3'd2) begin
      dec.mode = MODE_TWO;
    end else begin
      dec.mode = MODE_GRID;
    end
    dec.right = (pos != 3'd0);
    dec.cols  = cols;
    dec.rows  = grid_rows(cnt, cols);
    dec.col   = slot.col;
    dec.row   = slot.row;
    dec.aw    = aw_diff[12] ? '0 : aw_diff[11:0];
    dec.ah    = ah_diff[12] ? '0 : ah_diff[11:0];
  end

  // Content size net of inner gaps, and the two-window split
  always_comb begin
    cw_diff    = {1'b0, s1.aw} - {1'b0, gap_total(s1.cols)};
    ch_diff    = {1'b0, s1.ah} - {1'b0, gap_total(s1.rows)};
    split_diff = {1'b0, s1.aw} - 13'(INNER_GAP);

    s2_next.mode  = s1.mode;
    s2_next.right = s1.right;
    s2_next.cols  = s1.cols;
    s2_next.rows  = s1.rows;
    s2_next.col   = s1.col;
    s2_next.row   = s1.row;
    s2_next.aw    = s1.aw;
    s2_next.ah    = s1.ah;
    s2_next.cw    = cw_diff[12] ? '0 : cw_diff[11:0];
    s2_next.ch    = ch_diff[12] ? '0 : ch_diff[11:0];
    s2_next.split = split_diff[12] ? '0 : split_diff[11:1];
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    s1       <= dec;
    out_data <= s2_next;
  end

endmodule
`default_nettype wire

// ----- rtl/core/twl_divide.sv -----
`default_nettype none
module twl_divide (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  twl_pkg::front_t in_data,
  output logic            out_valid,
  output twl_pkg::div_t   out_data
);
  import twl_pkg::*;

  typedef struct packed {
    pix_t  q;
    grid_t r;
  } qr_t;

  front_t s3;
  logic   s3_valid;
  pix_t   q0x;
  pix_t   q0y;
  qr_t    fx;
  qr_t    fy;
  div_t   s4_next;

  // Quotient estimate, exact or one short
  function automatic pix_t quot_est(input pix_t x, input grid_t d);
    logic [23:0] prod;
    prod = 24'(x) * 24'(RECIP3);
    unique case (d)
      2'd1:    quot_est = x;
      2'd2:    quot_est = x >> 1;
      default: quot_est = prod[RECIP_SHIFT +: 12];
    endcase
  endfunction

  // One compare-and-subtract correction gives quotient and remainder
  function automatic qr_t quot_fix(input pix_t x, input pix_t q0, input grid_t d);
    logic [13:0] rem;
    qr_t         res;
    rem = 14'(x) - 14'(q0) * 14'(d);
    if (rem >= 14'(d)) begin
      res.q = q0 + 12'd1;
      res.r = 2'(rem - 14'(d));
    end else begin
      res.q = q0;
      res.r = 2'(rem);
    end
    return res;
  endfunction

  // Stage the reciprocal products
  always_ff @(posedge clk) begin
    s3  <= in_data;
    q0x <= quot_est(in_data.cw, in_data.cols);
    q0y <= quot_est(in_data.ch, in_data.rows);
  end

  // Correct and pass on tile size and leftover pixels
  always_comb begin
    fx = quot_fix(s3.cw, q0x, s3.cols);
    fy = quot_fix(s3.ch, q0y, s3.rows);

    s4_next.mode  = s3.mode;
    s4_next.right = s3.right;
    s4_next.col   = s3.col;
    s4_next.row   = s3.row;
    s4_next.aw    = s3.aw;
    s4_next.ah    = s3.ah;
    s4_next.split = s3.split;
    s4_next.bw    = fx.q;
    s4_next.bh    = fy.q;
    s4_next.ew    = fx.r;
    s4_next.eh    = fy.r;
  end

  always_ff @(posedge clk) begin
    out_data <= s4_next;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s3_valid  <= in_valid;
      out_valid <= s3_valid;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/twl_place.sv -----
`default_nettype none
module twl_place (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  twl_pkg::div_t in_data,
  output logic          done,
  output twl_pkg::pix_t target_left,
  output twl_pkg::pix_t target_top,
  output twl_pkg::pix_t target_span_x,
  output twl_pkg::pix_t target_span_y,
  output twl_pkg::pix_t start_left,
  output twl_pkg::pix_t start_top,
  output twl_pkg::pix_t start_span_x,
  output twl_pkg::pix_t start_span_y
);
  import twl_pkg::*;

  typedef struct packed {
    spix_t dx;
    spix_t dy;
    spix_t sw;
    spix_t sh;
  } inset_t;

  grid_t       ext_x;
  grid_t       ext_y;
  logic [13:0] step_x;
  logic [13:0] step_y;
  spix_t       tx_next;
  spix_t       ty_next;
  spix_t       tw_next;
  spix_t       th_next;
  logic        s5_valid;
  mode_t       s5_mode;
  spix_t       tx;
  spix_t       ty;
  spix_t       tw;
  spix_t       th;
  inset_t      ins;

  function automatic pix_t sat12(input spix_t v);
    if (v < 0) begin
      return '0;
    end else if (v > 14'sd4095) begin
      return '1;
    end else begin
      return v[11:0];
    end
  endfunction

  // Tile rectangle for the layout case
  always_comb begin
    ext_x  = (in_data.col < in_data.ew) ? in_data.col : in_data.ew;
    ext_y  = (in_data.row < in_data.eh) ? in_data.row : in_data.eh;
    step_x = 14'(in_data.bw) + 14'(INNER_GAP);
    step_y = 14'(in_data.bh) + 14'(INNER_GAP);
    unique case (in_data.mode)
      MODE_ONE: begin
        tx_next = spix_t'(AREA_LEFT);
        ty_next = spix_t'(AREA_TOP);
        tw_next = spix_t'(in_data.aw);
        th_next = spix_t'(in_data.ah);
      end
      MODE_TWO: begin
        ty_next = spix_t'(AREA_TOP);
        th_next = spix_t'(in_data.ah);
        if (in_data.right) begin
          // Right half takes the odd pixel
          tx_next = spix_t'(14'(AREA_LEFT) + 14'(in_data.split) + 14'(INNER_GAP));
          tw_next = spix_t'(14'(in_data.aw) - 14'(in_data.split) - 14'(INNER_GAP));
        end else begin
          tx_next = spix_t'(AREA_LEFT);
          tw_next = spix_t'(in_data.split);
        end
      end
      default: begin
        // Grid: leftover pixels go to the first columns and rows
        tx_next = spix_t'(14'(AREA_LEFT) + 14'(in_data.col) * step_x + 14'(ext_x));
        ty_next = spix_t'(14'(AREA_TOP) + 14'(in_data.row) * step_y + 14'(ext_y));
        tw_next = spix_t'(14'(in_data.bw) + 14'(in_data.col < in_data.ew));
        th_next = spix_t'(14'(in_data.bh) + 14'(in_data.row < in_data.eh));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s5_mode <= in_data.mode;
    tx      <= tx_next;
    ty      <= ty_next;
    tw      <= tw_next;
    th      <= th_next;
  end

  // Inset of the start rectangle
  always_comb begin
    unique case (s5_mode)
      MODE_ONE: begin
        ins.dx = spix_t'(ONE_DX);
        ins.dy = spix_t'(ONE_DY);
        ins.sw = spix_t'(ONE_SW);
        ins.sh = spix_t'(ONE_SH);
      end
      MODE_TWO: begin
        ins.dx = spix_t'(TWO_DX);
        ins.dy = spix_t'(TWO_DY);
        ins.sw = spix_t'(TWO_SW);
        ins.sh = spix_t'(TWO_SH);
      end
      default: begin
        ins.dx = spix_t'(GRID_DX);
        ins.dy = spix_t'(GRID_DY);
        ins.sw = spix_t'(GRID_SW);
        ins.sh = spix_t'(GRID_SH);
      end
    endcase
  end

  // Saturate into the output registers
  always_ff @(posedge clk) begin
    target_left   <= sat12(tx);
    target_top    <= sat12(ty);
    target_span_x <= sat12(tw);
    target_span_y <= sat12(th);
    start_left    <= sat12(tx + ins.dx);
    start_top     <= sat12(ty + ins.dy);
    start_span_x  <= sat12(tw - ins.sw);
    start_span_y  <= sat12(th - ins.sh);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s5_valid <= in_valid;
      done     <= s5_valid;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tiled_window_layout.sv -----
// Pipeline: done and the result leave together from the last of six register stages
// (decode, gap trim, reciprocal product, quotient fix, tile place, saturate).
// Throughput: one request per cycle; busy is low whenever rst is low.
// Reset: rst clears the stage valid bits and sets the screen to 1024 x 768.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module tiled_window_layout (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [2:0]    open_count,
  input  logic [2:0]    slot_position,
  output logic          done,
  output twl_pkg::pix_t target_left,
  output twl_pkg::pix_t target_top,
  output twl_pkg::pix_t target_span_x,
  output twl_pkg::pix_t target_span_y,
  output twl_pkg::pix_t start_left,
  output twl_pkg::pix_t start_top,
  output twl_pkg::pix_t start_span_x,
  output twl_pkg::pix_t start_span_y,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import twl_pkg::*;

  pix_t   screen_width;
  pix_t   screen_height;
  logic   in_valid;
  logic   front_valid;
  front_t front_data;
  logic   div_valid;
  div_t   div_data;

  // Hold off requests only while in reset
  assign busy     = rst;
  assign in_valid = start && !busy;

  twl_cfg_regs u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .screen_width  (screen_width),
    .screen_height (screen_height)
  );

  twl_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .open_count    (open_count),
    .slot_position (slot_position),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .out_valid     (front_valid),
    .out_data      (front_data)
  );

  twl_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  twl_place u_place (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (div_valid),
    .in_data       (div_data),
    .done          (done),
    .target_left   (target_left),
    .target_top    (target_top),
    .target_span_x (target_span_x),
    .target_span_y (target_span_y),
    .start_left    (start_left),
    .start_top     (start_top),
    .start_span_x  (start_span_x),
    .start_span_y  (start_span_y)
  );

endmodule
`default_nettype wire

// ----- rtl/core/twl_checker.sv -----
`default_nettype none
module twl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [11:0] target_left,
  input wire logic [11:0] target_top,
  input wire logic [11:0] target_span_x,
  input wire logic [11:0] target_span_y,
  input wire logic [11:0] start_left,
  input wire logic [11:0] start_top,
  input wire logic [11:0] start_span_x,
  input wire logic [11:0] start_span_y
);

  // Every accepted request yields its result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 done)
    else $error("accepted request produced no result");

  // No result without a matching earlier request
  a_result_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 6))
    else $error("result without a matching request");

  // Start rectangle never sits left of or above the target
  a_start_inside: assert property (@(posedge clk) disable iff (rst)
    done |-> (start_left >= target_left) && (start_top >= target_top))
    else $error("start corner outside target");

  // Start rectangle never larger than the target
  a_start_smaller: assert property (@(posedge clk) disable iff (rst)
    done |-> (start_span_x <= target_span_x) && (start_span_y <= target_span_y))
    else $error("start size exceeds target");

endmodule

bind tiled_window_layout twl_checker u_twl_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .target_left   (target_left),
  .target_top    (target_top),
  .target_span_x (target_span_x),
  .target_span_y (target_span_y),
  .start_left    (start_left),
  .start_top     (start_top),
  .start_span_x  (start_span_x),
  .start_span_y  (start_span_y)
);
`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none
module tb;
  import twl_pkg::*;

  // Geometry of the tiler, pixels
  localparam int WIN_LIMIT  = 6;
  localparam int BAR        = 30;
  localparam int EDGE_GAP   = 12;
  localparam int TILE_GAP   = 12;
  localparam int DROP_SHADE = 4;
  localparam int PIPE_WAIT  = 10;
  localparam int RAND_ITEMS = 90;
  localparam int RUN_LIMIT  = 400000;

  // Eight output fields, target_left in the low slot
  typedef logic [7:0][11:0] rect_pair_t;

  class layout_scoreboard;
    int scr_w = 1024;
    int scr_h = 768;
    int errors = 0;
    rect_pair_t expected_rects[$];

    function int floor0(int v);
      return (v < 0) ? 0 : v;
    endfunction

    function pix_t clip_pix(int v);
      if (v < 0) return 12'd0;
      if (v > 4095) return 12'd4095;
      return 12'(v);
    endfunction

    function string field_label(int i);
      case (i)
        0: return "target_left";
        1: return "target_top";
        2: return "target_span_x";
        3: return "target_span_y";
        4: return "start_left";
        5: return "start_top";
        6: return "start_span_x";
        default: return "start_span_y";
      endcase
    endfunction

    // Tile one window in the current work area
    function rect_pair_t place_window(logic [2:0] cnt, logic [2:0] rank);
      int n, p, ax, ay, aw, ah, tx, ty, tw, th, dx, dy, sw, sh;
      int split, cols, rows, cw, ch, bw, ew, bh, eh, col, row;
      rect_pair_t r;
      n = cnt;
      p = rank;
      if (n < 1) n = 1;
      if (n > WIN_LIMIT) n = WIN_LIMIT;
      if (p >= n) p = n - 1;
      ax = EDGE_GAP;
      ay = BAR + EDGE_GAP;
      aw = floor0(scr_w - 2 * EDGE_GAP - DROP_SHADE);
      ah = floor0(scr_h - BAR - 2 * EDGE_GAP - DROP_SHADE);
      if (n == 1) begin
        tx = ax; ty = ay; tw = aw; th = ah;
        dx = 24; dy = 16; sw = 48; sh = 32;
      end else if (n == 2) begin
        split = floor0(aw - TILE_GAP) / 2;
        ty = ay; th = ah;
        if (p == 0) begin
          tx = ax;
          tw = split;
        end else begin
          tx = ax + split + TILE_GAP;
          tw = aw - split - TILE_GAP;
        end
        dx = 20; dy = 12; sw = 40; sh = 24;
      end else begin
        cols = 1;
        while (cols * cols < n) cols++;
        rows = (n + cols - 1) / cols;
        cw = floor0(aw - (cols - 1) * TILE_GAP);
        ch = floor0(ah - (rows - 1) * TILE_GAP);
        bw = cw / cols;
        ew = cw % cols;
        bh = ch / rows;
        eh = ch % rows;
        col = p % cols;
        row = p / cols;
        tx = ax + col * (bw + TILE_GAP) + ((col < ew) ? col : ew);
        ty = ay + row * (bh + TILE_GAP) + ((row < eh) ? row : eh);
        tw = bw + ((col < ew) ? 1 : 0);
        th = bh + ((row < eh) ? 1 : 0);
        dx = 18; dy = 12; sw = 36; sh = 24;
      end
      r[0] = clip_pix(tx);
      r[1] = clip_pix(ty);
      r[2] = clip_pix(tw);
      r[3] = clip_pix(th);
      r[4] = clip_pix(tx + dx);
      r[5] = clip_pix(ty + dy);
      r[6] = clip_pix(tw - sw);
      r[7] = clip_pix(th - sh);
      return r;
    endfunction

    function void note_request(logic [2:0] cnt, logic [2:0] rank);
      expected_rects.push_back(place_window(cnt, rank));
    endfunction

    function void check_result(rect_pair_t got);
      rect_pair_t want;
      if (expected_rects.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_rects.pop_front();
      for (int i = 0; i < 8; i++) begin
        if (want[i] !== got[i]) begin
          errors++;
          $display("%0t: %s expected %0d actual %0d", $time, field_label(i),
                   want[i], got[i]);
        end
      end
    endfunction

    function int pending();
      return expected_rects.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  open_count;
  logic [2:0]  slot_position;
  logic        done;
  pix_t        target_left, target_top, target_span_x, target_span_y;
  pix_t        start_left, start_top, start_span_x, start_span_y;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  layout_scoreboard sb = new;
  int reg_errors = 0;

  tiled_window_layout u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .open_count    (open_count),
    .slot_position (slot_position),
    .done          (done),
    .target_left   (target_left),
    .target_top    (target_top),
    .target_span_x (target_span_x),
    .target_span_y (target_span_y),
    .start_left    (start_left),
    .start_top     (start_top),
    .start_span_x  (start_span_x),
    .start_span_y  (start_span_y),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Note each accepted request
  always @(posedge clk) begin
    if (!rst && start && !busy) sb.note_request(open_count, slot_position);
  end

  // Check each result strobe
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result({start_span_y, start_span_x, start_top, start_left,
                       target_span_y, target_span_x, target_top, target_left});
    end
  end

  // Hold one request until accepted
  task automatic send_request(logic [2:0] cnt, logic [2:0] rank);
    @(negedge clk);
    start         <= 1'b1;
    open_count    <= cnt;
    slot_position <= rank;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start for the requested idle span, with noise on the fields
  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start         <= 1'b0;
      open_count    <= 3'($urandom_range(0, 7));
      slot_position <= 3'($urandom_range(0, 7));
    end
  endtask

  // Drain all pending results, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, int val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * int'(idx));
    pwdata  <= {20'($urandom_range(0, 1048575)), 12'(val)};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_check(reg_idx_t idx, int val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 3'(4 * int'(idx));
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[11:0] !== 12'(val)) begin
      reg_errors++;
      $display("%0t: register %s expected %0d actual %0d", $time, idx.name(),
               12'(val), prdata[11:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_screen(int w, int h);
    apb_write(REG_SCREEN_WIDTH, w);
    apb_write(REG_SCREEN_HEIGHT, h);
    sb.scr_w = w;
    sb.scr_h = h;
    apb_check(REG_SCREEN_WIDTH, w);
    apb_check(REG_SCREEN_HEIGHT, h);
  endtask

  // Every count including zero and overflow, first and last rank, rank past the end
  task automatic directed_sweep();
    for (int c = 0; c < 8; c++) begin
      send_request(3'(c), 3'd0);
      if (c > 1) send_request(3'(c), 3'(c - 1));
      send_request(3'(c), 3'd7);
    end
  endtask

  // Bursts of mostly well-formed requests with random gaps
  task automatic random_traffic(int items);
    int issued, burst, gap, n;
    bit paused, no_gaps;
    issued = 0;
    paused = 0;
    while (issued < items) begin
      burst = $urandom_range(1, 24);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < burst && issued < items; i++) begin
        if ($urandom_range(0, 99) < 85) begin
          n = $urandom_range(1, WIN_LIMIT);
          send_request(3'(n), 3'($urandom_range(0, n - 1)));
        end else begin
          send_request(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        end
        issued++;
        if (!no_gaps && $urandom_range(0, 4) == 0) idle_cycles($urandom_range(1, 3));
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) idle_cycles(gap);
      // Hold off until the pipeline is empty once per run
      if (!paused && issued >= items / 2) begin
        wait_idle();
        paused = 1;
      end
    end
  endtask

  task automatic run_phase();
    directed_sweep();
    random_traffic(RAND_ITEMS);
    wait_idle();
  endtask

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    open_count    = 3'd0;
    slot_position = 3'd0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = 3'd0;
    pwdata        = 32'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset screen first, then 320 x 200, largest, zero, tiny and random screens, and the reset size again
    run_phase();
    set_screen(320, 200);
    run_phase();
    set_screen(4095, 4095);
    run_phase();
    set_screen(0, 0);
    run_phase();
    set_screen(27, 57);
    run_phase();
    set_screen(35, 65);
    run_phase();
    set_screen(45, 85);
    run_phase();
    set_screen($urandom_range(320, 4095), $urandom_range(200, 4095));
    run_phase();
    set_screen($urandom_range(320, 4095), $urandom_range(200, 4095));
    run_phase();
    set_screen(1024, 768);
    run_phase();

    if (sb.errors == 0 && reg_errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

endmodule
`default_nettype wire
